FILE: sv/lphm_pkg.sv
// Package for the linear probing hash map: sizes, codes and shared types.
// Used by the channel interfaces, the slot store and the top level.
package lphm_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

	localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 7'd42;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_VALID = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_RESP
	} fsm_state_t;

	typedef struct packed {
		slot_state_t       status;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} slot_rd_t;

	typedef struct packed {
		logic              status_we;
		logic              key_we;
		logic              value_we;
		logic [IDX_W-1:0]  idx;
		slot_state_t       status;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} slot_wr_t;

endpackage

FILE: sv/lphm_ifs.sv
// Request and response channel interfaces for the hash map.
// Depends on lphm_pkg for field widths.
interface lphm_req_if import lphm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [KEY_W-1:0]  key;
	logic [VAL_W-1:0]  value_in;

	modport source (output valid, output op, output key, output value_in, input ready);
	modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

interface lphm_rsp_if import lphm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [VAL_W-1:0]  value_out;
	logic [CNT_W-1:0]  entry_count;

	modport source (output valid, output status, output value_out, output entry_count,
		input ready);
	modport sink   (input valid, input status, input value_out, input entry_count,
		output ready);
endinterface

FILE: sv/lphm_slot_store.sv
// Slot store: per-slot state flags, key memory and value memory.
// One registered read port, one write port. Depends on lphm_pkg.
module lphm_slot_store import lphm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  rd_idx,
	output slot_rd_t          rd,
	input  slot_wr_t          wr
);

	slot_state_t       state_q [ENTRIES];
	logic [KEY_W-1:0]  key_mem [ENTRIES];
	logic [VAL_W-1:0]  val_mem [ENTRIES];

	slot_state_t       rd_state_q;
	logic [KEY_W-1:0]  rd_key_q;
	logic [VAL_W-1:0]  rd_val_q;

	// slot flags clear to empty at reset; keys and values need no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				state_q[i] <= SLOT_EMPTY;
			end
			rd_state_q <= SLOT_EMPTY;
		end else begin
			if (wr.status_we) begin
				state_q[wr.idx] <= wr.status;
			end
			rd_state_q <= state_q[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr.idx] <= wr.key;
		end
		rd_key_q <= key_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (wr.value_we) begin
			val_mem[wr.idx] <= wr.value;
		end
		rd_val_q <= val_mem[rd_idx];
	end

	assign rd.status = rd_state_q;
	assign rd.key    = rd_key_q;
	assign rd.value  = rd_val_q;

endmodule

FILE: sv/linear_probe_hash_map.sv
// Linear probing hash map, 64 slots, key home slot = key mod 64.
// After a request transfer, each probed slot takes a memory read state (S_READ), then
// a compare state (S_CMP), for P = 1..64 slots; S_RESP then loads the output register
// once it is free or being drained. A new request is taken only in S_IDLE.
// An unused op code skips the probe and goes to S_RESP. Reset clears all slots to empty,
// the entry count to 0 and fill_limit to 42, at once, with no clearing pass.
module linear_probe_hash_map import lphm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lphm_req_if.sink          req,
	lphm_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	fsm_state_t        state_q, state_d;

	// request held for the whole probe sequence
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;

	// probe position and the first free slot seen on the path
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  step_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  fill_limit_q;

	logic [ST_W-1:0]   res_status_q;
	logic [VAL_W-1:0]  res_value_q;

	// output register
	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [CNT_W-1:0]  out_count_q;

	slot_rd_t          rd;
	slot_wr_t          wr;

	logic              req_xfer;
	logic              out_load;
	logic              hit;
	logic              stop_probe;
	logic              cand_found;
	logic [IDX_W-1:0]  cand_idx;
	logic              done;
	logic              cnt_inc;
	logic              cnt_dec;
	logic [ST_W-1:0]   res_status_d;
	logic [VAL_W-1:0]  res_value_d;

	lphm_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_q),
		.rd     (rd),
		.wr     (wr)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	// load the response once the output register is free or being drained
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	// compare unit: one slot per visit of S_CMP
	assign hit        = (rd.status == SLOT_VALID) && (rd.key == key_q);
	assign stop_probe = (rd.status == SLOT_EMPTY) || (step_q == LAST_STEP);
	assign cand_found = free_found_q || (rd.status != SLOT_VALID);
	assign cand_idx   = free_found_q ? free_idx_q : idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					state_d = (req.op == OP_NONE) ? S_RESP : S_READ;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = done ? S_RESP : S_READ;
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// probe decisions and slot writes
	always_comb begin
		wr           = '0;
		wr.status    = SLOT_EMPTY;
		done         = 1'b0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		res_status_d = ST_MISSING;
		res_value_d  = '0;
		case (state_q)
			S_CMP: begin
				if (op_q == OP_INSERT) begin
					if (hit) begin
						// existing key: update the value in place
						wr.value_we  = 1'b1;
						wr.idx       = idx_q;
						wr.value     = val_q;
						done         = 1'b1;
						res_status_d = ST_OK;
					end else if (stop_probe) begin
						done = 1'b1;
						if (count_q >= fill_limit_q || !cand_found) begin
							res_status_d = ST_FULL;
						end else begin
							// new key goes to the first free slot on the path
							wr.status_we = 1'b1;
							wr.key_we    = 1'b1;
							wr.value_we  = 1'b1;
							wr.idx       = cand_idx;
							wr.status    = SLOT_VALID;
							wr.key       = key_q;
							wr.value     = val_q;
							cnt_inc      = 1'b1;
							res_status_d = ST_OK;
						end
					end
				end else begin
					if (hit) begin
						done         = 1'b1;
						res_status_d = ST_OK;
						res_value_d  = rd.value;
						if (op_q == OP_REMOVE) begin
							// leave a tombstone so later keys stay reachable
							wr.status_we = 1'b1;
							wr.idx       = idx_q;
							wr.status    = SLOT_TOMB;
							cnt_dec      = (count_q != '0);
						end
					end else if (stop_probe) begin
						done = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			fill_limit_q <= FILL_LIMIT_RST;
			out_valid_q  <= 1'b0;
			free_found_q <= 1'b0;
			step_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				fill_limit_q <= cfg_wdata;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (req_xfer) begin
				step_q       <= '0;
				free_found_q <= 1'b0;
			end else if (state_q == S_CMP && !done) begin
				step_q <= step_q + IDX_W'(1);
				if (!free_found_q && rd.status != SLOT_VALID) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q         <= req.op;
			key_q        <= req.key;
			val_q        <= req.value_in;
			idx_q        <= req.key[IDX_W-1:0];
			res_status_q <= ST_MISSING;
			res_value_q  <= '0;
		end else if (state_q == S_CMP) begin
			if (done) begin
				res_status_q <= res_status_d;
				res_value_q  <= res_value_d;
			end else begin
				// advance to the next slot, wrapping at the end of the table
				idx_q <= idx_q + IDX_W'(1);
				if (!free_found_q && rd.status != SLOT_VALID) begin
					free_idx_q <= idx_q;
				end
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_count_q  <= count_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.value_out   = out_value_q;
	assign rsp.entry_count = out_count_q;

endmodule

FILE: tb/linear_probe_hash_map_tb.sv
// Self-checking testbench for the linear probing hash map: random and directed
// insert, get and remove traffic, checked against a shadow copy of the slot table.
// Depends on lphm_pkg, the lphm_req_if and lphm_rsp_if channels and the map RTL.
module linear_probe_hash_map_tb;
	import lphm_pkg::*;

	// One request and one response as the predictor sees them
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} map_req_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [VAL_W-1:0]  value;
		logic [CNT_W-1:0]  count;
	} map_rsp_t;

	localparam int HOLD_CYCLES = 300;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Block inputs, known from time zero
	logic              drv_valid  = 1'b0;
	logic [OP_W-1:0]   drv_op     = OP_NONE;
	logic [KEY_W-1:0]  drv_key    = '0;
	logic [VAL_W-1:0]  drv_value  = '0;
	logic              sink_ready = 1'b0;
	logic              cfg_we     = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata  = '0;

	lphm_req_if req_ch ();
	lphm_rsp_if rsp_ch ();

	assign req_ch.valid    = drv_valid;
	assign req_ch.op       = drv_op;
	assign req_ch.key      = drv_key;
	assign req_ch.value_in = drv_value;
	assign rsp_ch.ready    = sink_ready;

	linear_probe_hash_map DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the slot table and the fill limit
	slot_state_t       shadow_state [ENTRIES];
	logic [KEY_W-1:0]  shadow_key   [ENTRIES];
	logic [VAL_W-1:0]  shadow_val   [ENTRIES];
	logic [CNT_W-1:0]  shadow_count;
	logic [CNT_W-1:0]  shadow_limit;

	map_req_t          pending_reqs  [$];
	map_rsp_t          expected_rsps [$];
	logic [KEY_W-1:0]  key_pool      [$];

	int  n_queued      = 0;
	int  n_taken       = 0;
	int  mismatch_cnt  = 0;
	int  src_idle_pct  = 0;
	int  snk_stall_pct = 0;
	bit  req_taken     = 1'b0;
	bit  hold_arm      = 1'b0;
	bit  hold_done     = 1'b0;
	int  hold_left     = 0;

	initial forever #5 clk = ~clk;

	// Apply one request to the shadow table and return the response it must produce.
	// A lookup stops at a key match or an empty slot and walks past tombstones;
	// an insert of a new key takes the first slot on the path that is not valid.
	function automatic map_rsp_t hash_map_predict(map_req_t r);
		map_rsp_t          res;
		logic [IDX_W-1:0]  home;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  hit_idx;
		logic [IDX_W-1:0]  free_idx;
		bit                hit;
		bit                free_ok;
		res.status = ST_MISSING;
		res.value  = '0;
		home       = r.key[IDX_W-1:0];
		hit        = 1'b0;
		free_ok    = 1'b0;
		hit_idx    = '0;
		free_idx   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			idx = home + IDX_W'(i);
			if (shadow_state[idx] == SLOT_VALID && shadow_key[idx] == r.key) begin
				hit     = 1'b1;
				hit_idx = idx;
				break;
			end
			if (shadow_state[idx] == SLOT_EMPTY)
				break;
		end
		case (r.op)
			OP_INSERT: begin
				if (hit) begin
					// existing key: update in place, fill limit does not apply
					shadow_val[hit_idx] = r.value;
					res.status          = ST_OK;
				end else if (shadow_count >= shadow_limit) begin
					res.status = ST_FULL;
				end else begin
					for (int i = 0; i < ENTRIES; i++) begin
						idx = home + IDX_W'(i);
						if (shadow_state[idx] != SLOT_VALID) begin
							free_ok  = 1'b1;
							free_idx = idx;
							break;
						end
					end
					if (!free_ok) begin
						// every slot valid: only reachable with a limit above the table size
						res.status = ST_FULL;
					end else begin
						shadow_state[free_idx] = SLOT_VALID;
						shadow_key[free_idx]   = r.key;
						shadow_val[free_idx]   = r.value;
						shadow_count           = shadow_count + CNT_W'(1);
						res.status             = ST_OK;
					end
				end
			end
			OP_GET, OP_REMOVE: begin
				if (hit) begin
					res.value  = shadow_val[hit_idx];
					res.status = ST_OK;
					if (r.op == OP_REMOVE) begin
						shadow_state[hit_idx] = SLOT_TOMB;
						if (shadow_count != '0)
							shadow_count = shadow_count - CNT_W'(1);
					end
				end
			end
			default: ;
		endcase
		res.count = shadow_count;
		return res;
	endfunction

	// Random key, often forced onto a few home slots to build long probe chains,
	// some of them near the top of the table so that probing wraps to slot 0.
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		k = $urandom;
		case ($urandom_range(0, 3))
			0: ;
			1: k[IDX_W-1:0] = IDX_W'($urandom_range(0, 5));
			2: k[IDX_W-1:0] = IDX_W'($urandom_range(58, 63));
			default: k = $urandom_range(0, 255);
		endcase
		return k;
	endfunction

	task automatic offer(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] value);
		map_req_t r;
		r.op    = op;
		r.key   = key;
		r.value = value;
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	// Queue n random requests; add fresh keys to the pool first and draw mostly from
	// its recent part so that gets and removes hit stored keys.
	task automatic queue_random(input int n, input int fresh, input int ins_pct,
		input int rem_pct);
		int                pick;
		int                base;
		logic [OP_W-1:0]   op;
		logic [KEY_W-1:0]  key;
		for (int i = 0; i < fresh; i++)
			key_pool.push_back(rand_key());
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = OP_NONE;
			else if (pick < 3 + ins_pct)
				op = OP_INSERT;
			else if (pick < 3 + ins_pct + rem_pct)
				op = OP_REMOVE;
			else
				op = OP_GET;
			base = (key_pool.size() > 80) ? key_pool.size() - 80 : 0;
			if ($urandom_range(0, 9) == 0)
				key = rand_key();
			else
				key = key_pool[$urandom_range(base, key_pool.size() - 1)];
			offer(op, key, $urandom);
		end
	endtask

	// Wait until every queued request has transferred and every response is back
	task automatic wait_idle();
		do @(negedge clk);
		while (n_taken != n_queued || expected_rsps.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// Write the fill limit while the map is idle; mirror it in the shadow copy
	task automatic write_limit(input logic [CNT_W-1:0] limit);
		@(negedge clk);
		cfg_we       <= 1'b1;
		cfg_wdata    <= limit;
		shadow_limit  = limit;
		@(negedge clk);
		cfg_we       <= 1'b0;
	endtask

	// Set the idling mix for the next phase, away from the falling edge that uses it
	task automatic set_idling(input int src_pct, input int snk_pct);
		@(posedge clk);
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	// Request driver: hold the current item until it transfers, then advance to the
	// next pending item unless this cycle is picked as a gap.
	always @(negedge clk) begin
		map_req_t nxt;
		if (arst_n && !(drv_valid && !req_taken)) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nxt        = pending_reqs.pop_front();
				drv_valid <= 1'b1;
				drv_op    <= nxt.op;
				drv_key   <= nxt.key;
				drv_value <= nxt.value;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Response sink: stall at random, and once per run hold off for a long stretch
	// so that the map holds a finished response and stops taking requests.
	always @(negedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Monitor: predict on every request transfer, check every response transfer
	// against the oldest prediction, field by field.
	always @(posedge clk) begin
		map_req_t  seen;
		map_rsp_t  want;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (req_taken) begin
			seen.op    = req_ch.op;
			seen.key   = req_ch.key;
			seen.value = req_ch.value_in;
			expected_rsps.push_back(hash_map_predict(seen));
			n_taken++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("response with no request outstanding: status %0d value_out %0h",
					rsp_ch.status, rsp_ch.value_out);
				mismatch_cnt++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status,
						rsp_ch.status);
					mismatch_cnt++;
				end
				if (rsp_ch.value_out !== want.value) begin
					$error("value_out mismatch: expected %0h, actual %0h", want.value,
						rsp_ch.value_out);
					mismatch_cnt++;
				end
				if (rsp_ch.entry_count !== want.count) begin
					$error("entry_count mismatch: expected %0d, actual %0d", want.count,
						rsp_ch.entry_count);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog: far beyond the slowest correct run (every request probing the whole
	// table, with all stalls and the long hold-off)
	initial begin
		#10_000_000;
		$display("linear_probe_hash_map test failed");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] k;
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_state[i] = SLOT_EMPTY;
			shadow_key[i]   = '0;
			shadow_val[i]   = '0;
		end
		shadow_count = '0;
		shadow_limit = FILL_LIMIT_RST;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset fill limit, no idling
		offer(OP_GET,    32'd0,        32'h1234_5678);  // lookup in an empty table
		offer(OP_REMOVE, 32'd5,        32'd0);          // remove from an empty table
		offer(OP_INSERT, 32'd0,        32'hFFFF_FFFF);
		offer(OP_INSERT, 32'd64,       32'd1);          // same home slot, next slot
		offer(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5); // home slot 63
		offer(OP_INSERT, 32'd63,       32'd2);          // probe wraps to slot 2
		offer(OP_GET,    32'd63,       32'd0);
		offer(OP_GET,    32'd128,      32'd0);          // miss, stops at empty slot
		offer(OP_REMOVE, 32'd0,        32'd0);          // leave a tombstone at slot 0
		offer(OP_GET,    32'd64,       32'd0);          // walk past the tombstone
		offer(OP_INSERT, 32'd64,       32'd3);          // update past tombstone, no copy
		offer(OP_INSERT, 32'd128,      32'd4);          // new key reuses the tombstone
		offer(OP_NONE,   32'd64,       32'hFFFF_FFFF);  // unused op code
		offer(OP_GET,    32'd0,        32'd0);
		offer(OP_INSERT, 32'hFFFF_FFFF, 32'd0);
		offer(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
		offer(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);         // second remove misses
		wait_idle();

		// Fill limit zero: new keys refused, stored keys still update and remove
		write_limit('0);
		offer(OP_INSERT, 32'd7,   32'd9);
		offer(OP_INSERT, 32'd64,  32'hDEAD_BEEF);
		offer(OP_REMOVE, 32'd128, 32'd0);
		wait_idle();

		// Random traffic at the reset limit, no idling
		write_limit(FILL_LIMIT_RST);
		queue_random(110, 40, 50, 20);
		wait_idle();

		// Low limit so that the full status is frequent; sender idles
		write_limit(7'd16);
		set_idling(67, 0);
		queue_random(100, 30, 50, 25);
		wait_idle();

		// Limit above the table size: fill all 64 slots on a few home slots, then
		// new keys find no free slot and misses sweep the whole table; receiver stalls
		write_limit(7'd127);
		set_idling(0, 67);
		for (int i = 0; i < 72; i++) begin
			k             = $urandom;
			k[IDX_W-1:0]  = IDX_W'($urandom_range(0, 7));
			key_pool.push_back(k);
			offer(OP_INSERT, k, $urandom);
		end
		queue_random(50, 4, 30, 5);
		wait_idle();

		// Limit equal to the table size, both sides idle, long receiver hold-off
		// while requests keep coming; mostly removes to drain the full table
		write_limit(7'd64);
		set_idling(25, 25);
		hold_arm = 1'b1;
		queue_random(130, 10, 35, 45);
		wait_idle();

		// Random limit, no idling
		write_limit(CNT_W'($urandom_range(1, 63)));
		set_idling(0, 0);
		queue_random(90, 30, 45, 25);
		wait_idle();

		// Let any stray response show up before the verdict
		repeat (140) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("linear_probe_hash_map test passed");
		end else begin
			$display("linear_probe_hash_map test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/lphm_pkg.sv
sv/lphm_ifs.sv
sv/lphm_slot_store.sv
sv/linear_probe_hash_map.sv
tb/linear_probe_hash_map_tb.sv
